FILE: hdl/tsvs_pkg.sv
// ============================================================================
// tsvs_pkg
// Shared types, constants and the multiply-accumulate program of the
// signed triangle volume sum unit.
// ============================================================================
package tsvs_pkg;

   // Result field widths.
   localparam int VOL_W      = 56;
   localparam int SUM_W      = 64;
   localparam int RSP_DATA_W = VOL_W + SUM_W;
   localparam int RSP_USER_W = 3;

   // Length of the multiply-accumulate program and its step counter width.
   localparam int UC_LEN = 21;
   localparam int UC_W   = 5;

   // Largest tetrahedron volume magnitude and the running sum limits.
   localparam logic [VOL_W-1:0] VOL_MAX = {1'b0, {(VOL_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Orientation class of one triangle's volume.
   typedef enum logic [1:0] {
      CLS_ADD  = 2'd0,
      CLS_SUB  = 2'd1,
      CLS_ZERO = 2'd2
   } cls_type;

   // Multiplier A operand: a narrow edge or vertex, or a wide stored vector.
   typedef enum logic [1:0] {
      ASRC_E1,
      ASRC_P1,
      ASRC_N,
      ASRC_PC
   } asrc_type;

   // Multiplier B operand: always a narrow vector component.
   typedef enum logic [2:0] {
      BSRC_E2,
      BSRC_P2,
      BSRC_D,
      BSRC_S,
      BSRC_P0
   } bsrc_type;

   // Where a finished accumulation goes.
   typedef enum logic [2:0] {
      DST_NONE,
      DST_N,
      DST_PC,
      DST_SIGN_D,
      DST_SIGN_S
   } dst_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_PREP,
      ST_DIV,
      ST_COMMIT
   } state_type;

   // One multiply-accumulate instruction.
   typedef struct packed {
      asrc_type   asrc;
      logic [1:0] aidx;
      bsrc_type   bsrc;
      logic [1:0] bidx;
      logic       neg;
      logic       first;
      dst_type    dst;
      logic [1:0] didx;
   } uop_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load;
      logic    mac;
      uop_type uop;
      logic    chunk_hi;
      logic    div_load;
      logic    div_step;
      logic    commit;
   } cmd_type;

   function automatic uop_type uop_make(input asrc_type asrc, input logic [1:0] aidx,
                                        input bsrc_type bsrc, input logic [1:0] bidx,
                                        input logic neg, input logic first,
                                        input dst_type dst, input logic [1:0] didx);
      uop_type r;
      r.asrc  = asrc;
      r.aidx  = aidx;
      r.bsrc  = bsrc;
      r.bidx  = bidx;
      r.neg   = neg;
      r.first = first;
      r.dst   = dst;
      r.didx  = didx;
      return r;
   endfunction

   // A wide operand is multiplied in two chunks, low then high.
   function automatic logic uop_is_wide(input uop_type u);
      return (u.asrc == ASRC_N) || (u.asrc == ASRC_PC);
   endfunction

   // Program: face normal, its two sign tests, vertex cross product and
   // the triple product left in the accumulator.
   function automatic uop_type uc_fetch(input logic [UC_W-1:0] step);
      uop_type r;
      unique case (step)
         // n = e1 x e2
         5'd0:  r = uop_make(ASRC_E1, 2'd1, BSRC_E2, 2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd1:  r = uop_make(ASRC_E1, 2'd2, BSRC_E2, 2'd1, 1'b1, 1'b0, DST_N, 2'd0);
         5'd2:  r = uop_make(ASRC_E1, 2'd2, BSRC_E2, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd3:  r = uop_make(ASRC_E1, 2'd0, BSRC_E2, 2'd2, 1'b1, 1'b0, DST_N, 2'd1);
         5'd4:  r = uop_make(ASRC_E1, 2'd0, BSRC_E2, 2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd5:  r = uop_make(ASRC_E1, 2'd1, BSRC_E2, 2'd0, 1'b1, 1'b0, DST_N, 2'd2);
         // n . 3(g - c)
         5'd6:  r = uop_make(ASRC_N, 2'd0, BSRC_D, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd7:  r = uop_make(ASRC_N, 2'd1, BSRC_D, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
         5'd8:  r = uop_make(ASRC_N, 2'd2, BSRC_D, 2'd2, 1'b0, 1'b0, DST_SIGN_D, 2'd0);
         // n . 3g
         5'd9:  r = uop_make(ASRC_N, 2'd0, BSRC_S, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd10: r = uop_make(ASRC_N, 2'd1, BSRC_S, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
         5'd11: r = uop_make(ASRC_N, 2'd2, BSRC_S, 2'd2, 1'b0, 1'b0, DST_SIGN_S, 2'd0);
         // pc = p1 x p2
         5'd12: r = uop_make(ASRC_P1, 2'd1, BSRC_P2, 2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd13: r = uop_make(ASRC_P1, 2'd2, BSRC_P2, 2'd1, 1'b1, 1'b0, DST_PC, 2'd0);
         5'd14: r = uop_make(ASRC_P1, 2'd2, BSRC_P2, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd15: r = uop_make(ASRC_P1, 2'd0, BSRC_P2, 2'd2, 1'b1, 1'b0, DST_PC, 2'd1);
         5'd16: r = uop_make(ASRC_P1, 2'd0, BSRC_P2, 2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd17: r = uop_make(ASRC_P1, 2'd1, BSRC_P2, 2'd0, 1'b1, 1'b0, DST_PC, 2'd2);
         // triple product p0 . (p1 x p2)
         5'd18: r = uop_make(ASRC_PC, 2'd0, BSRC_P0, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
         5'd19: r = uop_make(ASRC_PC, 2'd1, BSRC_P0, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
         5'd20: r = uop_make(ASRC_PC, 2'd2, BSRC_P0, 2'd2, 1'b0, 1'b0, DST_NONE, 2'd0);
         default: r = uop_make(ASRC_E1, 2'd0, BSRC_E2, 2'd0, 1'b0, 1'b0, DST_NONE, 2'd0);
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/tsvs_ctrl.sv
// ============================================================================
// tsvs_ctrl
// Sequencer: steps the multiply-accumulate program, runs the divider and
// hands each finished result to the output register.
// ============================================================================
module tsvs_ctrl #(
   parameter int COORD_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output tsvs_pkg::cmd_type cmd
);

   localparam int ACC_W     = 3 * COORD_BITS + 8;
   localparam int DIV_STEPS = (ACC_W + 7) / 8;

   tsvs_pkg::state_type            state_ff, state_in;
   logic [tsvs_pkg::UC_W-1:0]      cnt_ff, cnt_in;
   logic                           chunk_ff, chunk_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tsvs_pkg::uop_type              uop;
   logic                           out_free;

   assign uop      = tsvs_pkg::uc_fetch(cnt_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      chunk_in = chunk_ff;
      unique case (state_ff)
         tsvs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = tsvs_pkg::ST_MAC;
               cnt_in   = '0;
               chunk_in = 1'b0;
            end
         end
         tsvs_pkg::ST_MAC: begin
            if (tsvs_pkg::uop_is_wide(uop) && !chunk_ff) begin
               chunk_in = 1'b1;
            end else begin
               chunk_in = 1'b0;
               if (cnt_ff == tsvs_pkg::UC_W'(tsvs_pkg::UC_LEN - 1)) begin
                  state_in = tsvs_pkg::ST_DRAIN;
               end else begin
                  cnt_in = cnt_ff + tsvs_pkg::UC_W'(1);
               end
            end
         end
         tsvs_pkg::ST_DRAIN: begin
            state_in = tsvs_pkg::ST_PREP;
         end
         tsvs_pkg::ST_PREP: begin
            state_in = tsvs_pkg::ST_DIV;
            cnt_in   = '0;
         end
         tsvs_pkg::ST_DIV: begin
            if (cnt_ff == tsvs_pkg::UC_W'(DIV_STEPS - 1)) begin
               state_in = tsvs_pkg::ST_COMMIT;
            end else begin
               cnt_in = cnt_ff + tsvs_pkg::UC_W'(1);
            end
         end
         tsvs_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = tsvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsvs_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      req_tready   = (state_ff == tsvs_pkg::ST_IDLE);
      cmd.load     = (state_ff == tsvs_pkg::ST_IDLE) && req_tvalid;
      cmd.mac      = (state_ff == tsvs_pkg::ST_MAC);
      cmd.uop      = uop;
      cmd.chunk_hi = chunk_ff;
      cmd.div_load = (state_ff == tsvs_pkg::ST_PREP);
      cmd.div_step = (state_ff == tsvs_pkg::ST_DIV);
      cmd.commit   = (state_ff == tsvs_pkg::ST_COMMIT) && out_free;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsvs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         chunk_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted triangle starts the program at its first step, low chunk.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=>
         (state_ff == tsvs_pkg::ST_MAC) && (cnt_ff == '0) && !chunk_ff)
      else $error("program did not start at step zero");

   // The step counter never runs past the end of the program.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsvs_pkg::ST_MAC) |-> (cnt_ff < tsvs_pkg::UC_W'(tsvs_pkg::UC_LEN)))
      else $error("program step out of range");

   // The high chunk is only issued for a wide operand.
   a_chunk: assert property (@(posedge clock) disable iff (reset)
      chunk_ff |-> (state_ff == tsvs_pkg::ST_MAC) && tsvs_pkg::uop_is_wide(uop))
      else $error("high chunk issued for a narrow operand");

endmodule

FILE: hdl/tsvs_datapath.sv
// ============================================================================
// tsvs_datapath
// Operand registers, shared two-stage multiply-accumulate unit, radix-256
// divide-by-three unit and the saturating running sum.
// ============================================================================
module tsvs_datapath #(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS  = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tsvs_pkg::cmd_type                cmd,
   input  logic [12*COORD_BITS-1:0]         req_fields,
   output logic [tsvs_pkg::VOL_W-1:0]       tri_volume,
   output logic [tsvs_pkg::SUM_W-1:0]       running_volume,
   output tsvs_pkg::cls_type                sign_class,
   output logic                             saturated
);

   localparam int CB        = COORD_BITS;
   localparam int MW        = COORD_BITS + 2;       // chunk width of a wide operand
   localparam int NW        = MW + 1;               // signed narrow operand width
   localparam int WW        = 2 * MW;               // stored wide vector width
   localparam int PW        = 2 * NW;               // product width
   localparam int ACC_W     = 3 * COORD_BITS + 8;
   localparam int DIV_STEPS = (ACC_W + 7) / 8;
   localparam int QW        = DIV_STEPS * 8;
   localparam int QX        = (QW > tsvs_pkg::VOL_W) ? QW : tsvs_pkg::VOL_W;
   localparam logic [ACC_W:0] RND = (ACC_W + 1)'(3 * (2 ** FRAC_BITS));

   // Operand vectors.
   logic signed [NW-1:0] p0_ff [3];
   logic signed [NW-1:0] p1_ff [3];
   logic signed [NW-1:0] p2_ff [3];
   logic signed [NW-1:0] e1_ff [3];
   logic signed [NW-1:0] e2_ff [3];
   logic signed [NW-1:0] s_ff  [3];
   logic signed [NW-1:0] d_ff  [3];
   logic signed [NW-1:0] v0 [3];
   logic signed [NW-1:0] v1 [3];
   logic signed [NW-1:0] v2 [3];
   logic signed [NW-1:0] cc [3];
   logic signed [NW-1:0] sum3 [3];
   logic signed [WW-1:0] n_ff  [3];
   logic signed [WW-1:0] pc_ff [3];

   // Multiply stage.
   logic signed [WW-1:0]    wsel;
   logic signed [NW-1:0]    a_op, b_op;
   logic signed [PW-1:0]    prod_ff;
   logic                    wide;
   logic                    s2_valid_ff;
   logic                    s2_neg_ff, s2_first_ff, s2_hi_ff;
   tsvs_pkg::dst_type       s2_dst_ff, dst_eff;
   logic [1:0]              s2_didx_ff;

   // Accumulate stage.
   logic signed [ACC_W-1:0] acc_ff, acc_in, term, base;
   logic                    sa_neg_ff, sb_pos_ff, sb_zero_ff;

   // Divider and result.
   logic [ACC_W-1:0]        tabs;
   logic [ACC_W:0]          tsum;
   logic [QW-1:0]           q_ff, q_in;
   logic [1:0]              rem_ff, rem_in;
   logic [QX-1:0]           qx;
   logic [tsvs_pkg::VOL_W-1:0] mag, vol, vol_ff;
   tsvs_pkg::cls_type       cls, cls_ff;
   logic                    sb_eff_pos;
   logic [tsvs_pkg::SUM_W:0] sum_ext;
   logic [tsvs_pkg::SUM_W-1:0] run_ff, run_in;
   logic                    ovf, sat_ff;

   // Unpack the beat and form edges, 3g and 3(g - c).
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v0[k] = {{3{req_fields[k*CB + CB-1]}}, req_fields[k*CB +: CB]};
         v1[k] = {{3{req_fields[(3+k)*CB + CB-1]}}, req_fields[(3+k)*CB +: CB]};
         v2[k] = {{3{req_fields[(6+k)*CB + CB-1]}}, req_fields[(6+k)*CB +: CB]};
         cc[k] = {{3{req_fields[(9+k)*CB + CB-1]}}, req_fields[(9+k)*CB +: CB]};
         sum3[k] = v0[k] + v1[k] + v2[k];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            p0_ff[k] <= v0[k];
            p1_ff[k] <= v1[k];
            p2_ff[k] <= v2[k];
            e1_ff[k] <= v1[k] - v0[k];
            e2_ff[k] <= v2[k] - v0[k];
            s_ff[k]  <= sum3[k];
            d_ff[k]  <= sum3[k] - (cc[k] + (cc[k] <<< 1));
         end
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      wide = tsvs_pkg::uop_is_wide(cmd.uop);
      case (cmd.uop.asrc)
         tsvs_pkg::ASRC_N:  wsel = n_ff[cmd.uop.aidx];
         tsvs_pkg::ASRC_PC: wsel = pc_ff[cmd.uop.aidx];
         default:           wsel = '0;
      endcase
      case (cmd.uop.asrc)
         tsvs_pkg::ASRC_E1: a_op = e1_ff[cmd.uop.aidx];
         tsvs_pkg::ASRC_P1: a_op = p1_ff[cmd.uop.aidx];
         default: begin
            if (cmd.chunk_hi) begin
               a_op = {wsel[WW-1], wsel[WW-1:MW]};
            end else begin
               a_op = {1'b0, wsel[MW-1:0]};
            end
         end
      endcase
      case (cmd.uop.bsrc)
         tsvs_pkg::BSRC_E2: b_op = e2_ff[cmd.uop.bidx];
         tsvs_pkg::BSRC_P2: b_op = p2_ff[cmd.uop.bidx];
         tsvs_pkg::BSRC_D:  b_op = d_ff[cmd.uop.bidx];
         tsvs_pkg::BSRC_S:  b_op = s_ff[cmd.uop.bidx];
         default:           b_op = p0_ff[cmd.uop.bidx];
      endcase
      dst_eff = (!wide || cmd.chunk_hi) ? cmd.uop.dst : tsvs_pkg::DST_NONE;
   end

   // Multiply stage: product register plus the command for the add stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= cmd.mac;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= a_op * b_op;
      s2_neg_ff   <= cmd.uop.neg;
      s2_first_ff <= cmd.uop.first && !cmd.chunk_hi;
      s2_hi_ff    <= wide && cmd.chunk_hi;
      s2_dst_ff   <= dst_eff;
      s2_didx_ff  <= cmd.uop.didx;
   end

   // Accumulate stage.
   always_comb begin
      term = {{(ACC_W-PW){prod_ff[PW-1]}}, prod_ff};
      if (s2_hi_ff) begin
         term = term <<< MW;
      end
      base   = s2_first_ff ? '0 : acc_ff;
      acc_in = s2_neg_ff ? (base - term) : (base + term);
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
         case (s2_dst_ff)
            tsvs_pkg::DST_N:      n_ff[s2_didx_ff]  <= acc_in[WW-1:0];
            tsvs_pkg::DST_PC:     pc_ff[s2_didx_ff] <= acc_in[WW-1:0];
            tsvs_pkg::DST_SIGN_D: sa_neg_ff <= acc_in[ACC_W-1];
            tsvs_pkg::DST_SIGN_S: begin
               sb_pos_ff  <= !acc_in[ACC_W-1] && (acc_in != '0);
               sb_zero_ff <= (acc_in == '0);
            end
            default: ;
         endcase
      end
   end

   // Rounded magnitude of the triple product, pre-divided by 2^(F+1).
   always_comb begin
      tabs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      tsum = {1'b0, tabs} + RND;
   end

   // Divide by three, eight quotient bits per cycle, MSB first, in place.
   always_comb begin
      logic [2:0] t3;
      logic [1:0] r;
      logic [7:0] top;
      logic [7:0] qb;
      r   = rem_ff;
      top = q_ff[QW-1 -: 8];
      qb  = '0;
      for (int i = 7; i >= 0; i--) begin
         t3 = {r, top[i]};
         if (t3 >= 3'd3) begin
            qb[i] = 1'b1;
            r     = 2'(t3 - 3'd3);
         end else begin
            r = t3[1:0];
         end
      end
      rem_in = r;
      q_in   = {q_ff[QW-9:0], qb};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         q_ff   <= QW'(tsum >> (FRAC_BITS + 1));
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   // Clamp, orient and add to the running sum.
   always_comb begin
      qx  = QX'(q_ff);
      mag = (|qx[QX-1:tsvs_pkg::VOL_W-1]) ? tsvs_pkg::VOL_MAX : qx[tsvs_pkg::VOL_W-1:0];
      sb_eff_pos = sa_neg_ff ? (!sb_pos_ff && !sb_zero_ff) : sb_pos_ff;
      if (sb_zero_ff) begin
         cls = tsvs_pkg::CLS_ZERO;
         vol = '0;
      end else if (sb_eff_pos) begin
         cls = tsvs_pkg::CLS_SUB;
         vol = -mag;
      end else begin
         cls = tsvs_pkg::CLS_ADD;
         vol = mag;
      end
      sum_ext = {run_ff[tsvs_pkg::SUM_W-1], run_ff}
              + {{(tsvs_pkg::SUM_W + 1 - tsvs_pkg::VOL_W){vol[tsvs_pkg::VOL_W-1]}}, vol};
      ovf = sum_ext[tsvs_pkg::SUM_W] ^ sum_ext[tsvs_pkg::SUM_W-1];
      if (ovf) begin
         run_in = sum_ext[tsvs_pkg::SUM_W] ? tsvs_pkg::SUM_MIN : tsvs_pkg::SUM_MAX;
      end else begin
         run_in = sum_ext[tsvs_pkg::SUM_W-1:0];
      end
   end

   // Running sum is block state and clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (cmd.commit) begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         vol_ff <= vol;
         cls_ff <= cls;
         sat_ff <= ovf;
      end
   end

   assign tri_volume     = vol_ff;
   assign running_volume = run_ff;
   assign sign_class     = cls_ff;
   assign saturated      = sat_ff;

   // A clipped sum sits exactly at one of its limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.commit) && sat_ff |->
         (run_ff == tsvs_pkg::SUM_MAX) || (run_ff == tsvs_pkg::SUM_MIN))
      else $error("saturated sum not at a limit");

   // A triangle whose normal is perpendicular to its centroid adds nothing.
   a_zero_class: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.commit) && (cls_ff == tsvs_pkg::CLS_ZERO) |-> (vol_ff == '0))
      else $error("zeroed class with nonzero volume");

endmodule

FILE: hdl/triangle_signed_volume_sum_unit.sv
// ============================================================================
// triangle_signed_volume_sum_unit
// Signed surface-mesh volume accumulator: one boundary triangle per beat in,
// one signed tetrahedron volume and saturating running sum per beat out.
// One triangle at a time: a new beat is accepted only in the idle state, after
// the previous result is committed; throughput is set by 21 products through
// one shared multiplier and the eight-bit-per-cycle divide-by-three unit.
// Reset: synchronous, active high; clears the running sum and all handshakes.
// ============================================================================
module triangle_signed_volume_sum_unit #(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS  = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input beat.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y,
   // vert2_z, cell_center_x, cell_center_y, cell_center_z (COORD_BITS each)
   input  logic [((12*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // Result beat.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tri_volume [55:0], running_volume [119:56]
   output logic [tsvs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // sign_class [1:0], saturated [2]
   output logic [tsvs_pkg::RSP_USER_W-1:0]        rsp_tuser
);

   tsvs_pkg::cmd_type          cmd;
   logic [tsvs_pkg::VOL_W-1:0] tri_volume;
   logic [tsvs_pkg::SUM_W-1:0] running_volume;
   tsvs_pkg::cls_type          sign_class;
   logic                       saturated;

   tsvs_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tsvs_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_fields     (req_tdata[12*COORD_BITS-1:0]),
      .tri_volume     (tri_volume),
      .running_volume (running_volume),
      .sign_class     (sign_class),
      .saturated      (saturated)
   );

   // Pack the result beat.
   assign rsp_tdata = {running_volume, tri_volume};
   assign rsp_tuser = {saturated, sign_class};

endmodule
